FILE: hdl/kfi_pkg.sv
// Shared types, codes and the ease curve generator for the keyframe interpolator.
`timescale 1ns / 1ps
package kfi_pkg;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  localparam logic [1:0] MODE_JUMP   = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_COSINE = 2'd2;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  localparam logic [63:0] PI_Q28 = 64'd843314857;

  typedef struct packed {
    logic               func;
    logic [3:0]         key_index;
    logic [31:0]        key_time;
    logic [1:0]         key_mode;
    logic signed [15:0] key_x;
    logic signed [15:0] key_y;
    logic signed [15:0] key_z;
    logic [31:0]        query_time;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic               status;
  } out_t;

  // one stored keyframe
  typedef struct packed {
    logic [31:0]        ktime;
    logic [1:0]         mode;
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } key_entry_t;

  localparam int ENTRY_W = $bits(key_entry_t);

  // (1 - cos(pi*i/2^eb)) / 2 in Q0.16, from a Q4.28 sine series; elaboration only
  function automatic logic [15:0] ease_entry(input int eb, input int idx);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] e;
    a    = (PI_Q28 * 64'(idx)) >> (eb + 1);
    a2   = (a * a) >> 28;
    term = a;
    s    = a;
    term = ((term * a2) >> 28) / 64'd6;   s = s - term;
    term = ((term * a2) >> 28) / 64'd20;  s = s + term;
    term = ((term * a2) >> 28) / 64'd42;  s = s - term;
    term = ((term * a2) >> 28) / 64'd72;  s = s + term;
    term = ((term * a2) >> 28) / 64'd110; s = s - term;
    term = ((term * a2) >> 28) / 64'd156; s = s + term;
    term = ((term * a2) >> 28) / 64'd210; s = s - term;
    term = ((term * a2) >> 28) / 64'd272; s = s + term;
    e = (s * s + (64'd1 << 39)) >> 40;
    return (e > 64'd65535) ? 16'hFFFF : e[15:0];
  endfunction

endpackage

FILE: hdl/kfi_ram.sv
// Generic single write, single registered read RAM.
`timescale 1ns / 1ps
module kfi_ram #(
  parameter int WIDTH = 82,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/kfi_lane.sv
// One search lane: compares the query against one fixed key slot.
`timescale 1ns / 1ps
module kfi_lane #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic [31:0]      key_time,
  input  logic [31:0]      query,
  input  logic [CNT_W-1:0] n,
  output logic             gt,
  output logic             lt,
  output logic             hit
);
  assign gt  = key_time > query;
  assign lt  = key_time < query;
  // candidate for the after key: slot 1..n-1 with time past the query
  assign hit = gt && (IDX >= 1) && (CNT_W'(IDX) < n);
endmodule

FILE: hdl/kfi_div.sv
// Restoring divider: 16 quotient bits of num*2^16/den, with num < den.
`timescale 1ns / 1ps
module kfi_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [15:0] quot
);
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [4:0]  cnt;
  logic        run;
  logic [32:0] r2;

  assign r2 = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= num;
        dvs <= den;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        if (r2 >= {1'b0, dvs}) begin
          rem  <= 32'(r2 - {1'b0, dvs});
          quot <= {quot[14:0], 1'b1};
        end else begin
          rem  <= r2[31:0];
          quot <= {quot[14:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd15) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: hdl/kfi_mix.sv
// One component lane of the blend: v0 + round((v1 - v0) * w / 2^16).
`timescale 1ns / 1ps
module kfi_mix (
  input  logic               clk,
  input  logic               load,
  input  logic signed [15:0] v0,
  input  logic signed [15:0] v1,
  input  logic [15:0]        w,
  output logic signed [15:0] mixed
);
  logic signed [16:0] diff;
  logic signed [33:0] prod;
  logic signed [33:0] rnd;
  logic signed [17:0] delta;

  assign diff = 17'(v1) - 17'(v0);

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= 34'(diff * $signed({1'b0, w}));
    end
  end

  assign rnd   = prod + 34'sd32768;
  assign delta = rnd[33:16];
  assign mixed = v0 + delta[15:0];
endmodule

FILE: hdl/keyframe_interpolator.sv
// Top level of the keyframe interpolator.
`timescale 1ns / 1ps
// Keyframe animation interpolator (jump, linear, cosine ease).
//
// Input: an item transfers at a clock edge with start high and busy low.
//   func = write stores one keyframe in slot key_index in that cycle; no
//   result, busy stays low, a new item may follow next cycle.
//   func = evaluate looks up query_time and gives exactly one result.
// Output: done is high for one cycle with result valid; the receiver cannot
//   stall, so every result must be taken in that cycle.
// Config: cfg_we writes key_count (keys in use); write it only while idle.
// Evaluate: an empty table gives an empty result with busy kept low; edge
//   or jump answers take compare, select and the before key read; linear
//   and cosine add the after key read, the 16-step restoring divider for
//   the Q0.16 fraction and the blend. busy drops together with done, so the
//   next item can transfer at the edge that ends the done cycle.
// Search: one comparator lane per slot checks all keys at once; a
//   priority stage picks the first later key. Key data sits in a small RAM
//   read once for the before key and once for the after key.
// Reset: state idle, no result pending, key_count 0. Keys are undefined
//   until written.
module keyframe_interpolator #(
  parameter int MAX_KEYS  = 16,
  parameter int EASE_BITS = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  kfi_pkg::in_t item,
  output logic         busy,
  output logic         done,
  output kfi_pkg::out_t result,
  input  logic         cfg_we,
  input  logic [4:0]   cfg_data
);
  import kfi_pkg::*;

  // key_index is 4 bits, so at most 16 slots can ever be written
  localparam int SLOTS     = (MAX_KEYS > 16) ? 16 : MAX_KEYS;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int EASE_SIZE = 1 << EASE_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_CMP, S_SEL, S_RDB, S_RDA, S_DIV, S_WGT, S_MUL, S_OUT
  } state_t;

  state_t state;

  logic [4:0]        key_count;
  logic [31:0]       key_times [SLOTS];
  logic [31:0]       t_q;
  logic [CNT_W-1:0]  n_q;
  logic [CNT_W-1:0]  n_in;
  logic [SLOTS-1:0]  gt_l, lt_l, hit_l;
  logic [SLOTS-1:0]  gt_v, hit_v;
  logic              lt0;
  logic              edge_q;
  logic [SLOT_W-1:0] a_q;
  logic [SLOT_W-1:0] last;
  logic [SLOT_W-1:0] a_sel;
  logic [SLOT_W-1:0] sel_slot;
  logic              sel_edge;
  logic [SLOT_W-1:0] raddr;
  logic              wr_ok;
  key_entry_t        wentry;
  key_entry_t        rentry;
  key_entry_t        ent_b;
  key_entry_t        ent_a;
  logic [15:0]       quot;
  logic              div_done;
  logic [15:0]       w_q;
  logic [15:0]       ease_rom [EASE_SIZE];
  logic signed [15:0] mx, my, mz;

  // ease curve table, constant at elaboration
  for (genvar g = 0; g < EASE_SIZE; g++) begin : g_ease
    assign ease_rom[g] = ease_entry(EASE_BITS, g);
  end

  assign busy  = (state != S_IDLE);
  assign n_in  = (key_count > 5'(SLOTS)) ? CNT_W'(SLOTS) : key_count[CNT_W-1:0];
  assign wr_ok = ({28'd0, item.key_index} < 32'(MAX_KEYS));
  assign last  = SLOT_W'(n_q - CNT_W'(1));

  assign wentry = '{ktime: item.key_time, mode: item.key_mode,
                    z: item.key_z, y: item.key_y, x: item.key_x};

  // comparator lanes, one per slot
  for (genvar g = 0; g < SLOTS; g++) begin : g_lane
    kfi_lane #(.IDX(g), .CNT_W(CNT_W)) u_lane (
      .key_time(key_times[g]), .query(t_q), .n(n_q),
      .gt(gt_l[g]), .lt(lt_l[g]), .hit(hit_l[g])
    );
  end

  // merge: first later key, or an edge answer
  always_comb begin
    a_sel = last;
    for (int i = SLOTS - 1; i >= 1; i--) begin
      if (hit_v[i]) begin
        a_sel = SLOT_W'(i);
      end
    end
    if (!lt0) begin
      sel_slot = '0;
      sel_edge = 1'b1;
    end else if (!gt_v[last]) begin
      sel_slot = last;
      sel_edge = 1'b1;
    end else begin
      sel_slot = a_sel - SLOT_W'(1);
      sel_edge = 1'b0;
    end
  end

  assign raddr = (state == S_RDB) ? a_q : sel_slot;

  kfi_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ram (
    .clk(clk),
    .we(start && !busy && item.func == FUNC_WRITE && wr_ok),
    .waddr(item.key_index[SLOT_W-1:0]),
    .wdata(wentry),
    .raddr(raddr),
    .rdata(rentry)
  );

  kfi_div u_div (
    .clk(clk), .rst(rst), .start(state == S_RDA),
    .num(t_q - ent_b.ktime), .den(rentry.ktime - ent_b.ktime),
    .done(div_done), .quot(quot)
  );

  kfi_mix u_mx (.clk(clk), .load(state == S_MUL), .v0(ent_b.x), .v1(ent_a.x),
                .w(w_q), .mixed(mx));
  kfi_mix u_my (.clk(clk), .load(state == S_MUL), .v0(ent_b.y), .v1(ent_a.y),
                .w(w_q), .mixed(my));
  kfi_mix u_mz (.clk(clk), .load(state == S_MUL), .v0(ent_b.z), .v1(ent_a.z),
                .w(w_q), .mixed(mz));

  // key time copy for the lanes
  always_ff @(posedge clk) begin
    if (start && !busy && item.func == FUNC_WRITE && wr_ok) begin
      key_times[item.key_index[SLOT_W-1:0]] <= item.key_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      key_count <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        key_count <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (start && item.func == FUNC_EVAL) begin
            if (n_in == '0) begin
              done   <= 1'b1;
              result <= '{out_x: '0, out_y: '0, out_z: '0, status: STATUS_EMPTY};
            end else begin
              t_q   <= item.query_time;
              n_q   <= n_in;
              state <= S_CMP;
            end
          end
        end
        S_CMP: begin
          gt_v  <= gt_l;
          hit_v <= hit_l;
          lt0   <= lt_l[0];
          state <= S_SEL;
        end
        S_SEL: begin
          edge_q <= sel_edge;
          a_q    <= a_sel;
          state  <= S_RDB;
        end
        S_RDB: begin
          ent_b <= rentry;
          if (edge_q || !(rentry.mode == MODE_LINEAR || rentry.mode == MODE_COSINE)) begin
            done   <= 1'b1;
            result <= '{out_x: rentry.x, out_y: rentry.y, out_z: rentry.z,
                        status: STATUS_OK};
            state  <= S_IDLE;
          end else begin
            state <= S_RDA;
          end
        end
        S_RDA: begin
          ent_a <= rentry;
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_WGT;
          end
        end
        S_WGT: begin
          w_q   <= (ent_b.mode == MODE_COSINE) ? ease_rom[quot[15 -: EASE_BITS]] : quot;
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_OUT;
        end
        S_OUT: begin
          done   <= 1'b1;
          result <= '{out_x: mx, out_y: my, out_z: mz, status: STATUS_OK};
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
      start && !busy && item.func == FUNC_WRITE |=> !done)
    else $error("keyframe write produced a result");
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
      done && result.status == STATUS_EMPTY |->
        result.out_x == 0 && result.out_y == 0 && result.out_z == 0)
    else $error("empty table result not zero");
  a_div_ends: assert property (@(posedge clk) disable iff (rst)
      state == S_DIV && div_done |=> state == S_WGT)
    else $error("divider completion lost");
`endif
endmodule
